// ===== src/vto_pkg.sv =====
// Package: shared types and constants for the volume trigger occupancy core.
`timescale 1ns / 1ps
package vto_pkg;

    localparam int NUM_VOLUMES_DEF          = 16;
    localparam int OCCUPANTS_PER_VOLUME_DEF = 8;
    localparam int MAX_RESULTS              = 16;
    localparam int POS_W  = 24;
    localparam int EXT_W  = 23;
    localparam int ID_W   = 16;
    localparam int TIME_W = 32;
    localparam int ABS_W  = POS_W + 1;
    localparam int SQ_W   = 2 * ABS_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int RR_W   = 2 * EXT_W;

    localparam logic       KIND_PROBE = 1'b0;
    localparam logic       KIND_LOAD  = 1'b1;
    localparam logic [1:0] MODE_ENTER = 2'd0;
    localparam logic [1:0] MODE_EXIT  = 2'd1;
    localparam logic [1:0] MODE_DWELL = 2'd2;
    localparam logic [1:0] MODE_OFF   = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]          body;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
        logic [TIME_W-1:0]        tv;
    } probe_t;

    typedef struct packed {
        logic [ID_W-1:0]          slot;
        logic signed [POS_W-1:0]  cx;
        logic signed [POS_W-1:0]  cy;
        logic signed [POS_W-1:0]  cz;
        logic [EXT_W-1:0]         ex;
        logic [EXT_W-1:0]         ey;
        logic [EXT_W-1:0]         ez;
        logic                     sphere;
        logic [1:0]               mode;
        logic [ID_W-1:0]          evt;
        logic [TIME_W-1:0]        dwell;
    } load_t;

    typedef struct packed {
        logic             valid;
        logic             drop;
        logic [ID_W-1:0]  evt;
        logic [3:0]       slot;
        logic [1:0]       cause;
    } fire_t;

endpackage

// ===== src/vto_cell.sv =====
// One volume cell: slot configuration, occupant table and containment test.
`timescale 1ns / 1ps
module vto_cell #(
    parameter int SLOT = 0,
    parameter int OCC  = vto_pkg::OCCUPANTS_PER_VOLUME_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ld_we,
    input  vto_pkg::load_t  ld,
    input  logic            tok_in,
    input  vto_pkg::probe_t prb_in,
    output logic            tok_out,
    output vto_pkg::probe_t prb_out,
    output vto_pkg::fire_t  fire
);
    localparam int OW = (OCC > 1) ? $clog2(OCC) : 1;
    localparam logic [vto_pkg::ID_W-1:0] SLOT_ID = vto_pkg::ID_W'(SLOT);
    localparam logic [1:0] PH_DIFF = 2'd0;
    localparam logic [1:0] PH_SQ   = 2'd1;
    localparam logic [1:0] PH_ACT  = 2'd2;

    logic [1:0]                       mode_reg;
    logic signed [vto_pkg::POS_W-1:0] ctr_reg [3];
    logic [vto_pkg::EXT_W-1:0]        ext_reg [3];
    logic                             sph_reg;
    logic [vto_pkg::ID_W-1:0]         evt_reg;
    logic [vto_pkg::TIME_W-1:0]       dwell_reg;

    logic                             occ_valid_reg [OCC];
    logic [vto_pkg::ID_W-1:0]         occ_body_reg  [OCC];
    logic [vto_pkg::TIME_W-1:0]       occ_since_reg [OCC];
    logic                             occ_dwelt_reg [OCC];

    vto_pkg::probe_t                  prb_reg;
    logic                             act_reg;
    logic [1:0]                       ph_reg;
    logic                             tok_out_reg;
    vto_pkg::fire_t                   fire_reg;
    logic [vto_pkg::ABS_W-1:0]        ad_reg [3];
    logic [vto_pkg::SQ_W-1:0]         sq_reg [3];
    logic [vto_pkg::RR_W-1:0]         rr_reg;
    logic                             boxin_reg;

    logic signed [vto_pkg::ABS_W-1:0] diff [3];
    logic signed [vto_pkg::POS_W-1:0] pos  [3];
    logic [vto_pkg::SUM_W-1:0]        sum;
    logic                             contained;
    logic                             seat_found;
    logic [OW-1:0]                    seat_idx;
    logic                             free_found;
    logic [OW-1:0]                    free_idx;
    logic                             do_step;
    logic                             do_seat;
    logic                             do_drop;
    logic                             do_dwell;
    logic                             do_leave;
    logic                             fire_now;
    logic [vto_pkg::TIME_W-1:0]       elapsed;
    logic                             ld_hit;

    assign ld_hit = ld_we && (ld.slot == SLOT_ID);
    assign pos[0] = prb_reg.px;
    assign pos[1] = prb_reg.py;
    assign pos[2] = prb_reg.pz;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff[a] = {pos[a][vto_pkg::POS_W-1], pos[a]}
                    - {ctr_reg[a][vto_pkg::POS_W-1], ctr_reg[a]};
        end
    end

    always_comb
    begin
        sum = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
        contained = sph_reg ? (sum <= vto_pkg::SUM_W'(rr_reg)) : boxin_reg;
        seat_found = 1'b0;
        seat_idx   = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = 0; k < OCC; k++)
        begin
            if (occ_valid_reg[k])
            begin
                if (!seat_found && occ_body_reg[k] == prb_reg.body)
                begin
                    seat_found = 1'b1;
                    seat_idx   = OW'(k);
                end
            end
            else if (!free_found)
            begin
                free_found = 1'b1;
                free_idx   = OW'(k);
            end
        end
        elapsed  = prb_reg.tv - occ_since_reg[seat_idx];
        do_step  = act_reg && (ph_reg == PH_ACT) && (mode_reg != vto_pkg::MODE_OFF);
        do_seat  = do_step && contained && !seat_found && free_found;
        do_drop  = do_step && contained && !seat_found && !free_found;
        do_dwell = do_step && contained && seat_found && (mode_reg == vto_pkg::MODE_DWELL)
                && !occ_dwelt_reg[seat_idx] && (elapsed >= dwell_reg);
        do_leave = do_step && !contained && seat_found;
        fire_now = (do_seat && mode_reg == vto_pkg::MODE_ENTER) || do_dwell
                || (do_leave && mode_reg == vto_pkg::MODE_EXIT);
    end

    // configuration and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= vto_pkg::MODE_OFF;
            act_reg     <= 1'b0;
            ph_reg      <= PH_DIFF;
            tok_out_reg <= 1'b0;
            fire_reg    <= '0;
            for (int k = 0; k < OCC; k++)
            begin
                occ_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            tok_out_reg <= 1'b0;
            fire_reg    <= '0;
            if (ld_hit)
            begin
                mode_reg <= ld.mode;
                for (int k = 0; k < OCC; k++)
                begin
                    occ_valid_reg[k] <= 1'b0;
                end
            end
            if (tok_in)
            begin
                act_reg <= 1'b1;
                ph_reg  <= PH_DIFF;
            end
            else if (act_reg)
            begin
                case (ph_reg)
                    PH_DIFF: ph_reg <= PH_SQ;
                    PH_SQ:   ph_reg <= PH_ACT;
                    default:
                    begin
                        act_reg     <= 1'b0;
                        tok_out_reg <= 1'b1;
                    end
                endcase
            end
            for (int k = 0; k < OCC; k++)
            begin
                if (do_seat && free_idx == OW'(k))
                begin
                    occ_valid_reg[k] <= 1'b1;
                end
                if (do_leave && seat_idx == OW'(k))
                begin
                    occ_valid_reg[k] <= 1'b0;
                end
            end
            fire_reg.valid <= fire_now;
            fire_reg.drop  <= do_drop;
            if (fire_now)
            begin
                fire_reg.evt   <= evt_reg;
                fire_reg.slot  <= SLOT_ID[3:0];
                fire_reg.cause <= mode_reg;
            end
        end
    end

    // payload: slot data, occupant entries and pipeline values
    always_ff @(posedge clk)
    begin
        if (ld_hit)
        begin
            ctr_reg[0] <= ld.cx;
            ctr_reg[1] <= ld.cy;
            ctr_reg[2] <= ld.cz;
            ext_reg[0] <= ld.ex;
            ext_reg[1] <= ld.ey;
            ext_reg[2] <= ld.ez;
            sph_reg    <= ld.sphere;
            evt_reg    <= ld.evt;
            dwell_reg  <= ld.dwell;
        end
        if (tok_in)
        begin
            prb_reg <= prb_in;
        end
        if (act_reg && ph_reg == PH_DIFF)
        begin
            for (int a = 0; a < 3; a++)
            begin
                ad_reg[a] <= diff[a][vto_pkg::ABS_W-1] ? vto_pkg::ABS_W'(-diff[a])
                                                        : vto_pkg::ABS_W'(diff[a]);
            end
        end
        if (act_reg && ph_reg == PH_SQ)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sq_reg[a] <= ad_reg[a] * ad_reg[a];
            end
            rr_reg    <= ext_reg[0] * ext_reg[0];
            boxin_reg <= (ad_reg[0] <= vto_pkg::ABS_W'(ext_reg[0]))
                      && (ad_reg[1] <= vto_pkg::ABS_W'(ext_reg[1]))
                      && (ad_reg[2] <= vto_pkg::ABS_W'(ext_reg[2]));
        end
        for (int k = 0; k < OCC; k++)
        begin
            if (do_seat && free_idx == OW'(k))
            begin
                occ_body_reg[k]  <= prb_reg.body;
                occ_since_reg[k] <= prb_reg.tv;
                occ_dwelt_reg[k] <= 1'b0;
            end
            if (do_dwell && seat_idx == OW'(k))
            begin
                occ_dwelt_reg[k] <= 1'b1;
            end
        end
    end

    assign tok_out = tok_out_reg;
    assign prb_out = prb_reg;
    assign fire    = fire_reg;

endmodule

// ===== src/volume_trigger_occupancy_core.sv =====
// Top level: chain of volume cells, result ordering and the unseated counter.
`timescale 1ns / 1ps
// A load word (kind 1) writes one volume slot in the cycle it is accepted and
// empties that slot's occupants; it yields no results and leaves busy low. A
// probe word (kind 0) raises busy and travels down a chain of NUM_VOLUMES
// cells; each cell takes the difference, the squares and the decision in turn
// and then hands the token on. Busy stays high until the token has left the
// last cell, and the next word can be taken once busy is low. Each cell owns
// one slot and its occupant table, compared in parallel. Fired events come
// out in slot order, one per strobe cycle; the receiver cannot stall them.
// At most MAX_RESULTS events are given per probe, the final one with last set;
// a probe that fires nothing gives no strobe. Seating drops on a full table
// bump an internal saturating counter.
module volume_trigger_occupancy_core #(
    parameter int NUM_VOLUMES          = vto_pkg::NUM_VOLUMES_DEF,
    parameter int OCCUPANTS_PER_VOLUME = vto_pkg::OCCUPANTS_PER_VOLUME_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [15:0] index,
    input  logic [23:0] pos_x,
    input  logic [23:0] pos_y,
    input  logic [23:0] pos_z,
    input  logic [22:0] ext_x,
    input  logic [22:0] ext_y,
    input  logic [22:0] ext_z,
    input  logic        is_sphere,
    input  logic [1:0]  mode,
    input  logic [15:0] event_id,
    input  logic [31:0] time_value,
    output logic        strobe,
    output logic [15:0] fired_event,
    output logic [15:0] body_id,
    output logic [3:0]  volume_slot,
    output logic [1:0]  cause,
    output logic        last
);
    localparam int CNT_W = $clog2(vto_pkg::MAX_RESULTS + 1);

    logic            accept;
    logic            ld_we;
    vto_pkg::load_t  ld;
    logic            tok  [NUM_VOLUMES+1];
    vto_pkg::probe_t prb  [NUM_VOLUMES+1];
    vto_pkg::fire_t  fires [NUM_VOLUMES];
    vto_pkg::fire_t  fsum;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             pend_reg;
    logic [15:0]      pend_evt_reg;
    logic [3:0]       pend_slot_reg;
    logic [1:0]       pend_cause_reg;
    logic [15:0]      body_reg;
    logic [31:0]      unseated_reg;
    logic             strobe_reg;
    logic [15:0]      fired_event_reg;
    logic [3:0]       volume_slot_reg;
    logic [1:0]       cause_reg;
    logic             last_reg;
    logic             take;

    assign accept = start && !busy_reg;
    assign ld_we  = accept && (kind == vto_pkg::KIND_LOAD);

    assign ld.slot   = index;
    assign ld.cx     = pos_x;
    assign ld.cy     = pos_y;
    assign ld.cz     = pos_z;
    assign ld.ex     = ext_x;
    assign ld.ey     = ext_y;
    assign ld.ez     = ext_z;
    assign ld.sphere = is_sphere;
    assign ld.mode   = mode;
    assign ld.evt    = event_id;
    assign ld.dwell  = time_value;

    // inject the probe word at the head of the chain
    assign tok[0]      = accept && (kind == vto_pkg::KIND_PROBE);
    assign prb[0].body = index;
    assign prb[0].px   = pos_x;
    assign prb[0].py   = pos_y;
    assign prb[0].pz   = pos_z;
    assign prb[0].tv   = time_value;

    genvar g;
    generate
        for (g = 0; g < NUM_VOLUMES; g++)
        begin : g_cell
            vto_cell #(
                .SLOT (g),
                .OCC  (OCCUPANTS_PER_VOLUME)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ld_we   (ld_we),
                .ld      (ld),
                .tok_in  (tok[g]),
                .prb_in  (prb[g]),
                .tok_out (tok[g+1]),
                .prb_out (prb[g+1]),
                .fire    (fires[g])
            );
        end
    endgenerate

    // only the active cell drives nonzero fire fields, so merge by OR
    always_comb
    begin
        fsum = '0;
        for (int i = 0; i < NUM_VOLUMES; i++)
        begin
            fsum = fsum | fires[i];
        end
    end

    assign take = fsum.valid && (cnt_reg < CNT_W'(vto_pkg::MAX_RESULTS));

    // hold one event back so the final one can carry last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
            unseated_reg <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            done_reg   <= tok[NUM_VOLUMES];
            if (tok[0])
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                pend_reg <= 1'b0;
            end
            if (fsum.drop && unseated_reg != '1)
            begin
                unseated_reg <= unseated_reg + 32'd1;
            end
            if (take)
            begin
                cnt_reg    <= cnt_reg + CNT_W'(1);
                pend_reg   <= 1'b1;
                strobe_reg <= pend_reg;
            end
            if (done_reg)
            begin
                busy_reg   <= 1'b0;
                pend_reg   <= 1'b0;
                strobe_reg <= pend_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok[0])
        begin
            body_reg <= index;
        end
        if (take)
        begin
            pend_evt_reg   <= fsum.evt;
            pend_slot_reg  <= fsum.slot;
            pend_cause_reg <= fsum.cause;
        end
        if (take || done_reg)
        begin
            fired_event_reg <= pend_evt_reg;
            volume_slot_reg <= pend_slot_reg;
            cause_reg       <= pend_cause_reg;
            last_reg        <= done_reg;
        end
    end

    assign busy        = busy_reg;
    assign strobe      = strobe_reg;
    assign fired_event = fired_event_reg;
    assign body_id     = body_reg;
    assign volume_slot = volume_slot_reg;
    assign cause       = cause_reg;
    assign last        = last_reg;

    logic [NUM_VOLUMES-1:0] fire_vec;
    always_comb
    begin
        for (int i = 0; i < NUM_VOLUMES; i++)
        begin
            fire_vec[i] = fires[i].valid;
        end
    end

    a_one_cell_fires: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(fire_vec))
        else $error("more than one cell fired in a cycle");

    a_probe_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok[0] |=> busy_reg)
        else $error("probe accepted without raising busy");

    a_last_ends_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |-> !busy_reg)
        else $error("last result shown while probe still in flight");

    a_fire_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fsum.valid |-> busy_reg)
        else $error("cell fired with no probe in flight");

endmodule

// ===== test/tb_top.sv =====
// Testbench for the volume trigger occupancy core: directed table, random words, scoreboard.
`timescale 1ns / 1ps
// Method: drive load and probe words through start/busy, and keep an in-bench
// model of the volume table and the occupant tables. Each accepted probe
// queues the events that model expects, in slot order. A checker compares
// every strobe cycle with the oldest queued event, field by field.
// A short directed table comes first. Its rows carry typed events where the
// answer is plain. Most random words after it are well-formed scenes:
// bodies from a small pool probed near the loaded volumes while time
// advances. The rest are full-range noise words.
module tb_top;

    localparam int NVOL      = vto_pkg::NUM_VOLUMES_DEF;
    localparam int NOCC      = vto_pkg::OCCUPANTS_PER_VOLUME_DEF;
    localparam int RAND_WORDS = 400;
    localparam int STALL_LIMIT = 4000;

    // chk codes for the directed table
    localparam int CHK_MODEL = 0;
    localparam int CHK_NONE  = 1;
    localparam int CHK_ONE   = 2;

    typedef struct {
        bit              kind;
        bit [15:0]       idx;
        bit [23:0]       px, py, pz;
        bit [22:0]       ex, ey, ez;
        bit              sphere;
        bit [1:0]        mode;
        bit [15:0]       evt;
        bit [31:0]       tv;
    } word_t;

    typedef struct {
        bit [15:0] evt;
        bit [15:0] body;
        bit [3:0]  slot;
        bit [1:0]  cause;
        bit        last;
    } fired_t;

    typedef struct {
        word_t  w;
        int     chk;
        fired_t ev;
    } row_t;

    logic        clk, rst_n, start, busy;
    logic        kind, is_sphere, strobe, last;
    logic [15:0] index, event_id, fired_event, body_id;
    logic [23:0] pos_x, pos_y, pos_z;
    logic [22:0] ext_x, ext_y, ext_z;
    logic [1:0]  mode, cause;
    logic [31:0] time_value;
    logic [3:0]  volume_slot;

    volume_trigger_occupancy_core dut (.*);

    // volume table and occupant tables as the block should hold them
    longint    vol_c   [NVOL][3];
    bit [22:0] vol_ext [NVOL][3];
    bit        vol_sph [NVOL];
    bit [1:0]  vol_mode[NVOL];
    bit [15:0] vol_evt [NVOL];
    bit [31:0] vol_dwell[NVOL];
    bit        occ_valid[NVOL][NOCC];
    bit [15:0] occ_body [NVOL][NOCC];
    bit [31:0] occ_since[NVOL][NOCC];
    bit        occ_dwelt[NVOL][NOCC];
    bit [31:0] unseated;

    fired_t pending_events[$];
    int     errors = 0;
    int     n_loads = 0, n_probes = 0, n_events = 0;
    int     idle_cycles = 0;

    always
    begin
        clk = 1'b1; #2;
        clk = 1'b0; #2;
    end

    // Add one event at the tail of a queue.
    function automatic void append_event(ref fired_t q[$], input fired_t e);
        q.insert(q.size(), e);
    endfunction

    function automatic bit in_volume(int s, word_t w);
        longint d[3];
        longint sum;
        d[0] = longint'($signed(w.px)) - vol_c[s][0];
        d[1] = longint'($signed(w.py)) - vol_c[s][1];
        d[2] = longint'($signed(w.pz)) - vol_c[s][2];
        for (int a = 0; a < 3; a++)
            if (d[a] < 0) d[a] = -d[a];
        if (vol_sph[s])
        begin
            sum = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
            return sum <= longint'(vol_ext[s][0]) * longint'(vol_ext[s][0]);
        end
        for (int a = 0; a < 3; a++)
            if (d[a] > longint'(vol_ext[s][a])) return 0;
        return 1;
    endfunction

    // Apply one accepted word to the model; return the events it fires.
    function automatic void advance_occupancy(word_t w, ref fired_t evs[$]);
        int     seat, free_k;
        bit     contained, fire;
        fired_t ev;
        evs.delete();
        if (w.kind == vto_pkg::KIND_LOAD)
        begin
            if (w.idx < NVOL)
            begin
                vol_c[w.idx][0] = $signed(w.px);
                vol_c[w.idx][1] = $signed(w.py);
                vol_c[w.idx][2] = $signed(w.pz);
                vol_ext[w.idx][0] = w.ex;
                vol_ext[w.idx][1] = w.ey;
                vol_ext[w.idx][2] = w.ez;
                vol_sph[w.idx]   = w.sphere;
                vol_mode[w.idx]  = w.mode;
                vol_evt[w.idx]   = w.evt;
                vol_dwell[w.idx] = w.tv;
                for (int k = 0; k < NOCC; k++) occ_valid[w.idx][k] = 0;
            end
            return;
        end
        for (int s = 0; s < NVOL; s++)
        begin
            if (vol_mode[s] == vto_pkg::MODE_OFF) continue;
            contained = in_volume(s, w);
            fire = 0; seat = -1; free_k = -1;
            for (int k = 0; k < NOCC; k++)
                if (occ_valid[s][k])
                begin
                    if (seat < 0 && occ_body[s][k] == w.idx) seat = k;
                end
                else if (free_k < 0) free_k = k;
            if (contained && seat < 0)
            begin
                if (free_k < 0)
                begin
                    if (unseated != 32'hFFFF_FFFF) unseated++;
                end
                else
                begin
                    occ_valid[s][free_k] = 1;
                    occ_body[s][free_k]  = w.idx;
                    occ_since[s][free_k] = w.tv;
                    occ_dwelt[s][free_k] = 0;
                    fire = (vol_mode[s] == vto_pkg::MODE_ENTER);
                end
            end
            else if (contained)
            begin
                if (vol_mode[s] == vto_pkg::MODE_DWELL && !occ_dwelt[s][seat] &&
                    (w.tv - occ_since[s][seat]) >= vol_dwell[s])
                begin
                    occ_dwelt[s][seat] = 1;
                    fire = 1;
                end
            end
            else if (seat >= 0)
            begin
                fire = (vol_mode[s] == vto_pkg::MODE_EXIT);
                occ_valid[s][seat] = 0;
            end
            if (fire && evs.size() < vto_pkg::MAX_RESULTS)
            begin
                ev = '{vol_evt[s], w.idx, 4'(s), vol_mode[s], 1'b0};
                append_event(evs, ev);
            end
        end
        if (evs.size() > 0) evs[evs.size()-1].last = 1;
    endfunction

    function automatic word_t load_word(int slot, int cx, int cy, int cz, int ex, int ey,
                                        int ez, bit sph, bit [1:0] md, int ev, int dw);
        word_t w;
        w = '{vto_pkg::KIND_LOAD, 16'(slot), 24'(cx), 24'(cy), 24'(cz), 23'(ex), 23'(ey),
              23'(ez), sph, md, 16'(ev), 32'(dw)};
        return w;
    endfunction

    function automatic word_t probe_word(int body, int x, int y, int z, bit [31:0] t);
        word_t w;
        w = '{vto_pkg::KIND_PROBE, 16'(body), 24'(x), 24'(y), 24'(z), 23'h55AAAA, 23'h2A5555,
              23'h7FFFFF, 1'b1, vto_pkg::MODE_OFF, 16'hA5A5, t};
        return w;
    endfunction

    function automatic word_t noise_word();
        word_t w;
        w = '{1'($urandom), 16'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              23'($urandom), 23'($urandom), 23'($urandom), 1'($urandom), 2'($urandom),
              16'($urandom), 32'($urandom)};
        return w;
    endfunction

    // Hold the word on the pins from a falling edge until the block takes it,
    // then queue what it should fire.
    task automatic issue_word(word_t w, int chk, fired_t typed);
        fired_t evs[$];
        @(negedge clk);
        kind = w.kind; index = w.idx;
        pos_x = w.px; pos_y = w.py; pos_z = w.pz;
        ext_x = w.ex; ext_y = w.ey; ext_z = w.ez;
        is_sphere = w.sphere; mode = w.mode; event_id = w.evt; time_value = w.tv;
        start = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        advance_occupancy(w, evs);
        if (w.kind == vto_pkg::KIND_LOAD) n_loads++;
        else n_probes++;
        if (chk == CHK_NONE) evs.delete();
        else if (chk == CHK_ONE)
        begin
            evs.delete();
            append_event(evs, typed);
        end
        foreach (evs[i]) append_event(pending_events, evs[i]);
    endtask

    // Drop start for a random gap: mostly none, often short, sometimes long.
    task automatic idle_gap(bit quiet);
        int n, r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) n = 0;
        else if (r < 92) n = $urandom_range(1, 4);
        else n = $urandom_range(20, 70);
        if (n == 0) return;
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Compare each strobe cycle with the oldest expected event.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            fired_t e;
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event evt=%h body=%h slot=%0d cause=%0d last=%0d",
                         $time, fired_event, body_id, volume_slot, cause, last);
                errors++;
            end
            else
            begin
                e = pending_events.pop_front();
                n_events++;
                if (fired_event !== e.evt || body_id !== e.body || volume_slot !== e.slot ||
                    cause !== e.cause || last !== e.last)
                begin
                    $display("%0t: expected evt=%h body=%h slot=%0d cause=%0d last=%0d",
                             $time, e.evt, e.body, e.slot, e.cause, e.last);
                    $display("%0t:   actual evt=%h body=%h slot=%0d cause=%0d last=%0d",
                             $time, fired_event, body_id, volume_slot, cause, last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles where no word is taken and no event comes out.
    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d events outstanding",
                     $time, pending_events.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        row_t    rows[$];
        word_t   w;
        fired_t  none;
        int      s, r, quiet_left;
        bit [31:0] now;
        longint  off[3];

        start = 0; kind = 0; index = 0; pos_x = 0; pos_y = 0; pos_z = 0;
        ext_x = 0; ext_y = 0; ext_z = 0; is_sphere = 0; mode = 0; event_id = 0;
        time_value = 0; unseated = 0;
        none = '{0, 0, 0, 0, 0};
        for (int v = 0; v < NVOL; v++)
        begin
            vol_mode[v] = vto_pkg::MODE_OFF;
            for (int k = 0; k < NOCC; k++) occ_valid[v][k] = 0;
        end
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table. After reset every slot is disabled.
        rows.insert(rows.size(), '{probe_word(5, 0, 0, 0, 0), CHK_NONE, none});
        rows.insert(rows.size(), '{load_word(0, 0, 0, 0, 100, 100, 100, 0,
                                             vto_pkg::MODE_ENTER, 'h1111, 0),
                                   CHK_NONE, none});
        // slot out of range is ignored
        rows.insert(rows.size(), '{load_word(16, 0, 0, 0, 0, 0, 0, 0,
                                             vto_pkg::MODE_ENTER, 'h2222, 0),
                                   CHK_NONE, none});
        rows.insert(rows.size(), '{load_word(65535, 0, 0, 0, 0, 0, 0, 1,
                                             vto_pkg::MODE_EXIT, 'h3333, 0),
                                   CHK_NONE, none});
        // box edge is inclusive
        rows.insert(rows.size(), '{probe_word(5, 100, -100, 100, 10), CHK_ONE,
                                   '{16'h1111, 16'd5, 4'd0, vto_pkg::MODE_ENTER, 1'b1}});
        rows.insert(rows.size(), '{probe_word(5, 101, 0, 0, 20), CHK_NONE, none});
        // sphere at the far corner with the largest radius
        rows.insert(rows.size(), '{load_word(15, 8388607, 8388607, 8388607, 8388607, 0,
                                             8388607, 1, vto_pkg::MODE_EXIT, 'hFFFF, 0),
                                   CHK_NONE, none});
        rows.insert(rows.size(), '{probe_word(65535, 8388607, 8388607, 0, 30),
                                   CHK_NONE, none});
        rows.insert(rows.size(), '{probe_word(65535, -8388608, -8388608, -8388608, 40),
                                   CHK_ONE,
                                   '{16'hFFFF, 16'hFFFF, 4'd15, vto_pkg::MODE_EXIT, 1'b1}});
        // zero dwell, and time that wraps
        rows.insert(rows.size(), '{load_word(3, 0, 0, 0, 8388607, 8388607, 8388607, 0,
                                             vto_pkg::MODE_DWELL, 3, 0),
                                   CHK_NONE, none});
        rows.insert(rows.size(), '{probe_word(7, 0, 0, 0, 32'hFFFF_FFF0), CHK_MODEL, none});
        rows.insert(rows.size(), '{probe_word(7, 1, 1, 1, 5), CHK_MODEL, none});
        rows.insert(rows.size(), '{probe_word(7, 2, 2, 2, 6), CHK_MODEL, none});
        // fill occupant tables past their size; bodies that find no free seat are not seated
        for (int b = 0; b < NOCC + 1; b++)
            rows.insert(rows.size(), '{probe_word(100 + b, 0, 0, 0, 50 + b),
                                       CHK_MODEL, none});
        // disabled slot is skipped
        rows.insert(rows.size(), '{load_word(0, 0, 0, 0, 100, 100, 100, 0,
                                             vto_pkg::MODE_OFF, 'h1111, 0),
                                   CHK_NONE, none});
        rows.insert(rows.size(), '{probe_word(5, 0, 0, 0, 90), CHK_MODEL, none});

        foreach (rows[i])
        begin
            issue_word(rows[i].w, rows[i].chk, rows[i].ev);
            idle_gap(0);
        end

        // Random scenes: volumes near the origin, a small pool of bodies
        // wandering through them while time moves on.
        now = $urandom;
        quiet_left = 0;
        for (int i = 0; i < RAND_WORDS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                w = noise_word();
            else if (r < 22)
            begin
                s = ($urandom_range(0, 19) == 0) ? $urandom_range(NVOL, 65535)
                                                 : $urandom_range(0, NVOL - 1);
                w = load_word(s, $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                              $urandom_range(0, 4000) - 2000, $urandom_range(0, 1500),
                              $urandom_range(0, 1500), $urandom_range(0, 1500),
                              1'($urandom), 2'($urandom_range(0, 3)), $urandom,
                              ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400));
            end
            else
            begin
                // hover near a slot so inside and outside both occur
                s = $urandom_range(0, NVOL - 1);
                for (int a = 0; a < 3; a++)
                    off[a] = longint'($urandom_range(0, 3600)) - 1800;
                now += ($urandom_range(0, 30) == 0) ? $urandom : $urandom_range(0, 150);
                w = probe_word($urandom_range(0, 11), int'(vol_c[s][0] + off[0]),
                               int'(vol_c[s][1] + off[1]), int'(vol_c[s][2] + off[2]), now);
            end
            issue_word(w, CHK_MODEL, none);
            if (quiet_left > 0) quiet_left--;
            else if ($urandom_range(0, 29) == 0) quiet_left = $urandom_range(10, 40);
            idle_gap(quiet_left > 0);
        end

        @(negedge clk);
        start = 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (4 * NVOL + 20) @(posedge clk);
        if (pending_events.size() != 0) errors++;

        $display("Covered %0d loads and %0d probes, %0d events compared, %0d unseated drops.",
                 n_loads, n_probes, n_events, unseated);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
